// ----- sv/acm_pkg.sv -----
// Shared types and constants of the Aho-Corasick matcher.
// Used by the top level and the checker; depends on nothing.
package acm_pkg;

    localparam int NODES_DEF       = 4096;
    localparam int ALPHABET_DEF    = 26;
    localparam int TOTAL_WIDTH_DEF = 48;

    localparam int COUNT_W   = 13;
    localparam int COUNT_MAX = 4096;
    localparam int SYMBOL_W  = 5;
    localparam int IN_DATA_W = 8;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_BUILD  = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_BUILT = 2'd2
    } status_t;

endpackage

// ----- sv/acm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/acm_sat_add.sv -----
// Shared saturating adder for word counts and the running match total.
// Depends on nothing.
module acm_sat_add #(
    parameter int WIDTH = 48
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] limit,
    output logic [WIDTH-1:0] sum
);

    logic [WIDTH:0] raw;

    always_comb begin
        raw = {1'b0, a} + {1'b0, b};
        sum = (raw > {1'b0, limit}) ? limit : raw[WIDTH-1:0];
    end

endmodule

// ----- sv/aho_corasick_matcher.sv -----
// Top level of the Aho-Corasick matcher: sequencer, trie memories and result register.
// Depends on acm_pkg, acm_ram and acm_sat_add.
//
// The input channel carries one command per transaction: tuser holds the mode, tdata the
// letter index and tlast closes a pattern or a text. Every command answers exactly one
// result transaction: tdata holds matches_here and match_total, tuser the status and
// tlast marks the end of a text.
// Commands are handled one at a time; s_tready is high only while the sequencer is idle.
// Every step is one read of a memory port followed by a decision. A command runs from
// the accepting edge to the edge that loads the result register, and the next command
// is taken in the cycle after that. Its steps by command:
//   add symbol      follow the goto or allocate a new node, or report full; a last letter
//                   also bumps the word count of a node other than the root
//   search symbol   follow failure links until a goto or the root, then add the end count;
//                   a letter out of range adds the root count, and before build a search
//                   answers at once with no match
//   build           for the root and then each queued node, scan its letters; for each
//                   child walk the failure chain to set its link and summed end count
//   clear           clear the root row and empty the trie
// The result register holds a finished result while the receiver stalls; the sequencer
// waits on it before presenting the next one, and a new command may still be taken.
module aho_corasick_matcher #(
    parameter int NODES       = acm_pkg::NODES_DEF,
    parameter int ALPHABET    = acm_pkg::ALPHABET_DEF,
    parameter int TOTAL_WIDTH = acm_pkg::TOTAL_WIDTH_DEF,
    localparam int OUT_DATA_W = ((acm_pkg::COUNT_W + TOTAL_WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [acm_pkg::IN_DATA_W-1:0] s_tdata,   // [4:0] symbol
    input  logic [1:0]                    s_tuser,   // [1:0] mode
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_DATA_W-1:0]         m_tdata,   // matches_here, then match_total
    output logic [1:0]                    m_tuser,   // [1:0] status
    output logic                          m_tlast
);

    localparam int NODE_W = $clog2(NODES);
    localparam int SYM_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int GA_W   = $clog2(NODES * ALPHABET);
    localparam int CW     = acm_pkg::COUNT_W;

    localparam logic [NODE_W-1:0]      LAST_NODE = NODE_W'(NODES - 1);
    localparam logic [SYM_W-1:0]       LAST_SYM  = SYM_W'(ALPHABET - 1);
    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_OUT,
        S_ADD_RD, S_ADD_DEC, S_ADD_NEW, S_ADD_LAST, S_ADD_INC,
        S_B_ROOT, S_B_ROOT2, S_B_ERD, S_B_ELAT, S_B_SCAN, S_B_U, S_B_VRD, S_B_VCHK,
        S_B_F, S_B_SETF, S_B_SUM, S_B_POP, S_B_PLAT,
        S_S_RD, S_S_CHK, S_S_GO, S_S_END, S_S_ACC
    } state_t;

    function automatic logic [GA_W-1:0] goto_addr(logic [NODE_W-1:0] n, logic [SYM_W-1:0] s);
        return GA_W'(n) * GA_W'(ALPHABET) + GA_W'(s);
    endfunction

    state_t state_reg, state_next;
    logic   reply_reg, reply_next;
    logic   last_reg, last_next;
    logic   built_reg, built_next;
    logic   done_reg, done_next;
    logic [1:0]             status_reg, status_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic [NODE_W-1:0]      node_count_reg, node_count_next;
    logic [NODE_W-1:0]      add_cur_reg, add_cur_next;
    logic [NODE_W-1:0]      srch_cur_reg, srch_cur_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [NODE_W-1:0]      fe_reg, fe_next;
    logic [NODE_W-1:0]      efail_reg, efail_next;
    logic [NODE_W-1:0]      u_reg, u_next;
    logic [NODE_W-1:0]      f_reg, f_next;
    logic [NODE_W-1:0]      head_reg, head_next;
    logic [NODE_W-1:0]      tail_reg, tail_next;
    logic [ALPHABET-1:0]    erow_reg, erow_next;
    logic [CW-1:0]          here_reg, here_next;
    logic [TOTAL_WIDTH-1:0] total_reg, total_next;
    logic                   m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_next;
    logic [1:0]             m_tuser_next;
    logic                   m_tlast_next;

    logic                goto_we, child_we, fail_we, end_we, own_we, queue_we;
    logic [GA_W-1:0]     goto_waddr, goto_raddr;
    logic [NODE_W-1:0]   goto_wdata, goto_rdata;
    logic [NODE_W-1:0]   child_waddr, child_raddr;
    logic [ALPHABET-1:0] child_wdata, child_rdata;
    logic [NODE_W-1:0]   fail_waddr, fail_raddr, fail_wdata, fail_rdata;
    logic [NODE_W-1:0]   end_waddr, end_raddr;
    logic [CW-1:0]       end_wdata, end_rdata;
    logic [NODE_W-1:0]   own_waddr, own_raddr;
    logic [CW-1:0]       own_wdata, own_rdata;
    logic [NODE_W-1:0]   queue_waddr, queue_raddr, queue_wdata, queue_rdata;

    logic [TOTAL_WIDTH-1:0] alu_a, alu_b, alu_lim, alu_sum;
    logic                   out_free;

    acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES * ALPHABET)) u_goto (
        .aclk, .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
        .raddr(goto_raddr), .rdata(goto_rdata)
    );
    acm_ram #(.WIDTH(ALPHABET), .DEPTH(NODES)) u_child (
        .aclk, .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
        .raddr(child_raddr), .rdata(child_rdata)
    );
    acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fail (
        .aclk, .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
        .raddr(fail_raddr), .rdata(fail_rdata)
    );
    acm_ram #(.WIDTH(CW), .DEPTH(NODES)) u_end (
        .aclk, .we(end_we), .waddr(end_waddr), .wdata(end_wdata),
        .raddr(end_raddr), .rdata(end_rdata)
    );
    acm_ram #(.WIDTH(CW), .DEPTH(NODES)) u_own (
        .aclk, .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
        .raddr(own_raddr), .rdata(own_rdata)
    );
    acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue (
        .aclk, .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(queue_raddr), .rdata(queue_rdata)
    );

    acm_sat_add #(.WIDTH(TOTAL_WIDTH)) u_alu (
        .a(alu_a), .b(alu_b), .limit(alu_lim), .sum(alu_sum)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        alu_a   = total_reg;
        alu_b   = TOTAL_WIDTH'(end_rdata);
        alu_lim = TOTAL_MAX;
        if (state_reg == S_ADD_INC) begin
            alu_a   = TOTAL_WIDTH'(own_rdata);
            alu_b   = TOTAL_WIDTH'(1);
            alu_lim = TOTAL_WIDTH'(acm_pkg::COUNT_MAX);
        end else if (state_reg == S_B_SUM) begin
            alu_a   = TOTAL_WIDTH'(own_rdata);
            alu_lim = TOTAL_WIDTH'(acm_pkg::COUNT_MAX);
        end
    end

    always_comb begin
        state_next      = state_reg;
        reply_next      = reply_reg;
        last_next       = last_reg;
        built_next      = built_reg;
        done_next       = done_reg;
        status_next     = status_reg;
        sym_next        = sym_reg;
        node_count_next = node_count_reg;
        add_cur_next    = add_cur_reg;
        srch_cur_next   = srch_cur_reg;
        node_next       = node_reg;
        fe_next         = fe_reg;
        efail_next      = efail_reg;
        u_next          = u_reg;
        f_next          = f_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        erow_next       = erow_reg;
        here_next       = here_reg;
        total_next      = total_reg;
        m_tvalid_next   = m_tvalid && !m_tready;
        m_tdata_next    = m_tdata;
        m_tuser_next    = m_tuser;
        m_tlast_next    = m_tlast;

        goto_we = 1'b0;  goto_waddr = goto_addr(add_cur_reg, sym_reg);
        goto_wdata = NODE_W'(node_count_reg + NODE_W'(1));
        goto_raddr = goto_addr(node_reg, sym_reg);
        child_we = 1'b0; child_waddr = add_cur_reg; child_wdata = '0;
        child_raddr = node_reg;
        fail_we = 1'b0;  fail_waddr = u_reg; fail_wdata = f_reg; fail_raddr = node_reg;
        end_we = 1'b0;   end_waddr = u_reg; end_wdata = alu_sum[CW-1:0]; end_raddr = f_reg;
        own_we = 1'b0;   own_waddr = add_cur_reg; own_wdata = '0; own_raddr = u_reg;
        queue_we = 1'b0; queue_waddr = tail_reg; queue_wdata = u_reg; queue_raddr = head_reg;

        case (state_reg)
            S_CLR: begin
                child_we = 1'b1; child_waddr = '0;
                end_we = 1'b1; end_waddr = '0; end_wdata = '0;
                own_we = 1'b1; own_waddr = '0;
                node_count_next = '0;
                add_cur_next    = '0;
                srch_cur_next   = '0;
                total_next      = '0;
                built_next      = 1'b0;
                state_next      = reply_reg ? S_OUT : S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    sym_next    = SYM_W'(s_tdata[acm_pkg::SYMBOL_W-1:0]);
                    last_next   = s_tlast;
                    here_next   = '0;
                    done_next   = 1'b0;
                    status_next = acm_pkg::ST_OK;
                    case (s_tuser)
                        acm_pkg::MODE_ADD: begin
                            built_next = 1'b0;
                            node_next  = add_cur_reg;
                            if (32'(s_tdata[acm_pkg::SYMBOL_W-1:0]) < ALPHABET) begin
                                state_next = S_ADD_RD;
                            end else begin
                                state_next = S_ADD_LAST;
                            end
                        end
                        acm_pkg::MODE_BUILD: begin
                            state_next = S_B_ROOT;
                        end
                        acm_pkg::MODE_SEARCH: begin
                            node_next = srch_cur_reg;
                            if (!built_reg) begin
                                status_next = acm_pkg::ST_NOT_BUILT;
                                state_next  = S_OUT;
                            end else if (32'(s_tdata[acm_pkg::SYMBOL_W-1:0]) < ALPHABET) begin
                                state_next = S_S_RD;
                            end else begin
                                node_next  = '0;
                                state_next = S_S_END;
                            end
                        end
                        default: begin
                            reply_next = 1'b1;
                            state_next = S_CLR;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_W'({total_reg, here_reg});
                    m_tuser_next  = status_reg;
                    m_tlast_next  = done_reg;
                    if (done_reg) begin
                        total_next    = '0;
                        srch_cur_next = '0;
                    end
                    reply_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_ADD_RD: begin
                child_raddr = add_cur_reg;
                goto_raddr  = goto_addr(add_cur_reg, sym_reg);
                state_next  = S_ADD_DEC;
            end
            S_ADD_DEC: begin
                if (child_rdata[sym_reg]) begin
                    add_cur_next = goto_rdata;
                    state_next   = S_ADD_LAST;
                end else if (node_count_reg != LAST_NODE) begin
                    node_count_next = NODE_W'(node_count_reg + NODE_W'(1));
                    child_we        = 1'b1;
                    child_wdata     = child_rdata | (ALPHABET'(1) << sym_reg);
                    goto_we         = 1'b1;
                    add_cur_next    = NODE_W'(node_count_reg + NODE_W'(1));
                    state_next      = S_ADD_NEW;
                end else begin
                    status_next = acm_pkg::ST_FULL;
                    if (last_reg) begin
                        add_cur_next = '0;
                    end
                    state_next = S_OUT;
                end
            end
            S_ADD_NEW: begin
                child_we = 1'b1;
                end_we = 1'b1; end_waddr = add_cur_reg; end_wdata = '0;
                own_we = 1'b1;
                state_next = S_ADD_LAST;
            end
            S_ADD_LAST: begin
                own_raddr = add_cur_reg;
                if (last_reg && add_cur_reg != '0) begin
                    state_next = S_ADD_INC;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_ADD_INC: begin
                own_we       = 1'b1;
                own_wdata    = alu_sum[CW-1:0];
                add_cur_next = '0;
                state_next   = S_OUT;
            end
            S_B_ROOT: begin
                own_raddr  = '0;
                state_next = S_B_ROOT2;
            end
            S_B_ROOT2: begin
                end_we = 1'b1; end_waddr = '0; end_wdata = own_rdata;
                fail_we = 1'b1; fail_waddr = '0; fail_wdata = '0;
                head_next  = '0;
                tail_next  = '0;
                node_next  = '0;
                state_next = S_B_ERD;
            end
            S_B_ERD: begin
                state_next = S_B_ELAT;
            end
            S_B_ELAT: begin
                erow_next  = child_rdata;
                fe_next    = (node_reg == '0) ? '0 : fail_rdata;
                efail_next = (node_reg == '0) ? '0 : fail_rdata;
                sym_next   = '0;
                state_next = S_B_SCAN;
            end
            S_B_SCAN: begin
                goto_raddr = goto_addr(node_reg, sym_reg);
                if (erow_reg[sym_reg]) begin
                    state_next = S_B_U;
                end else if (sym_reg == LAST_SYM) begin
                    state_next = S_B_POP;
                end else begin
                    sym_next = SYM_W'(sym_reg + SYM_W'(1));
                end
            end
            S_B_U: begin
                u_next = goto_rdata;
                f_next = '0;
                fe_next = fe_reg;
                if (node_reg == '0) begin
                    state_next = S_B_SETF;
                end else begin
                    state_next = S_B_VRD;
                end
            end
            S_B_VRD: begin
                child_raddr = fe_reg;
                fail_raddr  = fe_reg;
                state_next  = S_B_VCHK;
            end
            S_B_VCHK: begin
                goto_raddr = goto_addr(fe_reg, sym_reg);
                if (child_rdata[sym_reg]) begin
                    state_next = S_B_F;
                end else if (fe_reg == '0) begin
                    f_next     = '0;
                    state_next = S_B_SETF;
                end else begin
                    fe_next    = fail_rdata;
                    state_next = S_B_VRD;
                end
            end
            S_B_F: begin
                f_next     = goto_rdata;
                state_next = S_B_SETF;
            end
            S_B_SETF: begin
                fail_we    = 1'b1;
                queue_we   = 1'b1;
                tail_next  = NODE_W'(tail_reg + NODE_W'(1));
                state_next = S_B_SUM;
            end
            S_B_SUM: begin
                end_we  = 1'b1;
                fe_next = efail_reg;
                if (sym_reg == LAST_SYM) begin
                    state_next = S_B_POP;
                end else begin
                    sym_next   = SYM_W'(sym_reg + SYM_W'(1));
                    state_next = S_B_SCAN;
                end
            end
            S_B_POP: begin
                if (head_reg == tail_reg) begin
                    srch_cur_next = '0;
                    total_next    = '0;
                    built_next    = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    head_next  = NODE_W'(head_reg + NODE_W'(1));
                    state_next = S_B_PLAT;
                end
            end
            S_B_PLAT: begin
                node_next  = queue_rdata;
                state_next = S_B_ERD;
            end
            S_S_RD: begin
                state_next = S_S_CHK;
            end
            S_S_CHK: begin
                if (child_rdata[sym_reg]) begin
                    state_next = S_S_GO;
                end else if (node_reg == '0) begin
                    state_next = S_S_END;
                end else begin
                    node_next  = fail_rdata;
                    state_next = S_S_RD;
                end
            end
            S_S_GO: begin
                node_next  = goto_rdata;
                state_next = S_S_END;
            end
            S_S_END: begin
                end_raddr  = node_reg;
                state_next = S_S_ACC;
            end
            S_S_ACC: begin
                here_next     = end_rdata;
                total_next    = alu_sum;
                srch_cur_next = node_reg;
                done_next     = last_reg;
                state_next    = S_OUT;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            reply_reg      <= 1'b0;
            built_reg      <= 1'b0;
            node_count_reg <= '0;
            add_cur_reg    <= '0;
            srch_cur_reg   <= '0;
            total_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            m_tvalid       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            reply_reg      <= reply_next;
            built_reg      <= built_next;
            node_count_reg <= node_count_next;
            add_cur_reg    <= add_cur_next;
            srch_cur_reg   <= srch_cur_next;
            total_reg      <= total_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            m_tvalid       <= m_tvalid_next;
        end
        last_reg   <= last_next;
        done_reg   <= done_next;
        status_reg <= status_next;
        sym_reg    <= sym_next;
        node_reg   <= node_next;
        fe_reg     <= fe_next;
        efail_reg  <= efail_next;
        u_reg      <= u_next;
        f_reg      <= f_next;
        erow_reg   <= erow_next;
        here_reg   <= here_next;
        m_tdata    <= m_tdata_next;
        m_tuser    <= m_tuser_next;
        m_tlast    <= m_tlast_next;
    end

endmodule

// ----- sv/acm_checker.sv -----
// Port-level checks of the Aho-Corasick matcher, bound to its top level.
// Depends on acm_pkg and aho_corasick_matcher.
module acm_checker #(
    parameter int TOTAL_WIDTH = acm_pkg::TOTAL_WIDTH_DEF,
    localparam int OUT_DATA_W = ((acm_pkg::COUNT_W + TOTAL_WIDTH + 7) / 8) * 8
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [OUT_DATA_W-1:0]         m_tdata,
    input logic [1:0]                    m_tuser,
    input logic                          m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result transaction changed.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("A command was taken while another was in progress.");

    a_done_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == acm_pkg::ST_OK)
        else $error("A text ended on a result with an error status.");

    a_not_built_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == acm_pkg::ST_NOT_BUILT |->
            m_tdata[acm_pkg::COUNT_W-1:0] == '0 && !m_tlast)
        else $error("A search before build reported matches.");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[acm_pkg::COUNT_W-1:0] <= acm_pkg::COUNT_W'(acm_pkg::COUNT_MAX))
        else $error("Match count beyond its saturation limit.");

endmodule

bind aho_corasick_matcher acm_checker #(.TOTAL_WIDTH(TOTAL_WIDTH)) u_acm_checker (.*);
